/* design/nhs_pkg.sv */
// Shared constants, codes and types of the named heartbeat supervisor.
package nhs_pkg;

    localparam int SLOTS      = 8;
    localparam int NAME_BYTES = 7;

    localparam int NAME_W    = 56;
    localparam int KEY_BITS  = (NAME_BYTES >= 7) ? NAME_W : 8 * NAME_BYTES;
    localparam logic [NAME_W-1:0] NAME_MASK =
        (KEY_BITS == NAME_W) ? {NAME_W{1'b1}} : ((NAME_W'(1) << KEY_BITS) - NAME_W'(1));

    localparam int SIL_W     = 32;
    localparam int LIMIT_W   = 16;
    localparam int LSIZE_W   = 4;
    localparam int ELAPSED_W = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NUM_W  = $clog2(SLOTS + 1);
    localparam int CNT_W  = ($clog2(SLOTS + 1) > 4) ? $clog2(SLOTS + 1) : 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_SIZE  = 1'b1;

    localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST = 16'd30;
    localparam logic [LSIZE_W-1:0] LIST_SIZE_RST  = 4'd8;

    typedef enum logic [1:0] {
        ACT_REGISTER = 2'd0,
        ACT_RELEASE  = 2'd1,
        ACT_RESPONSE = 2'd2,
        ACT_TICK     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_REGISTERED = 3'd0,
        ST_CONFLICT   = 3'd1,
        ST_FULL       = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_NOTED      = 3'd5,
        ST_UNKNOWN    = 3'd6,
        ST_TICK       = 3'd7
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [NAME_W-1:0] echo_name;
        logic              alarm;
        logic [7:0]        missing_mask;
        logic [3:0]        missing_count;
    } t_result;

endpackage

/* design/nhs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module nhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/nhs_ctrl.sv */
// Slot walker: searches, ticks and reports over the name and counter memories.
module nhs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_action,
    input  logic [nhs_pkg::NAME_W-1:0]    i_device_name,
    input  logic [nhs_pkg::ELAPSED_W-1:0] i_elapsed_seconds,
    input  logic [nhs_pkg::LIMIT_W-1:0]   i_wait_limit,
    input  logic [nhs_pkg::LSIZE_W-1:0]   i_list_size,
    output logic                          o_busy,
    output logic                          o_done,
    output nhs_pkg::t_result              o_result,
    // memory side
    output logic [nhs_pkg::IDX_W-1:0]     o_raddr,
    input  logic [nhs_pkg::NAME_W-1:0]    i_name_rdata,
    input  logic [nhs_pkg::SIL_W-1:0]     i_sil_rdata,
    output logic                          o_name_we,
    output logic [nhs_pkg::IDX_W-1:0]     o_name_waddr,
    output logic [nhs_pkg::NAME_W-1:0]    o_name_wdata,
    output logic                          o_sil_we,
    output logic [nhs_pkg::IDX_W-1:0]     o_sil_waddr,
    output logic [nhs_pkg::SIL_W-1:0]     o_sil_wdata
);
    import nhs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_COMMIT
    } t_state;

    t_state                r_state, n_state;
    t_action               r_action, n_action;
    logic [NAME_W-1:0]     r_key, n_key;
    logic [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic [NUM_W-1:0]      r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [IDX_W-1:0]      r_pidx, n_pidx;
    logic [SLOTS-1:0]      r_valid, n_valid;
    logic                  r_hit, n_hit;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic                  r_hit_miss, n_hit_miss;
    logic                  r_free, n_free;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic [SLOTS-1:0]      r_mask, n_mask;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_done, n_done;
    t_result               r_result, n_result;

    logic [NUM_W-1:0]      active_n;
    logic                  slot_valid;
    logic [SIL_W:0]        sum;
    logic [SIL_W-1:0]      sat;
    logic                  miss;
    logic [SLOTS-1:0]      mask_fin;
    logic [CNT_W-1:0]      cnt_fin;
    t_status               status;

    // active slot count = min(list_size, SLOTS)
    always_comb begin
        if (int'(i_list_size) < SLOTS) begin
            active_n = NUM_W'(i_list_size);
        end else begin
            active_n = NUM_W'(SLOTS);
        end
    end

    assign o_raddr      = r_idx[IDX_W-1:0];
    assign slot_valid   = r_valid[r_pidx];
    assign sum          = {1'b0, i_sil_rdata} + (SIL_W + 1)'(r_elapsed);
    assign sat          = sum[SIL_W] ? {SIL_W{1'b1}} : sum[SIL_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_action   = r_action;
        n_key      = r_key;
        n_elapsed  = r_elapsed;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pidx     = r_pidx;
        n_valid    = r_valid;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_miss = r_hit_miss;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_mask     = r_mask;
        n_cnt      = r_cnt;
        n_done     = 1'b0;
        n_result   = r_result;

        o_name_we    = 1'b0;
        o_name_waddr = r_free_idx;
        o_name_wdata = r_key;
        o_sil_we     = 1'b0;
        o_sil_waddr  = r_pidx;
        o_sil_wdata  = sat;

        miss     = 1'b0;
        mask_fin = r_mask;
        cnt_fin  = r_cnt;
        status   = ST_TICK;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_action  = t_action'(i_action);
                    n_key     = i_device_name & NAME_MASK;
                    n_elapsed = i_elapsed_seconds;
                    n_idx     = '0;
                    n_hit     = 1'b0;
                    n_free    = 1'b0;
                    n_mask    = '0;
                    n_cnt     = '0;
                    n_state   = (active_n == '0) ? S_COMMIT : S_WALK;
                end
            end

            S_WALK: begin
                // issue the next slot read; its data returns in the next cycle
                if (r_idx != active_n) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + NUM_W'(1);
                end else begin
                    n_state = S_COMMIT;
                end

                if (r_pend) begin
                    if (r_action == ACT_TICK) begin
                        // add elapsed time, saturate, write back behind the read
                        o_sil_we = slot_valid;
                        miss     = slot_valid && (sat > SIL_W'(i_wait_limit));
                    end else begin
                        miss = slot_valid && (i_sil_rdata > SIL_W'(i_wait_limit));
                        if (slot_valid && (i_name_rdata == r_key) && !r_hit) begin
                            n_hit      = 1'b1;
                            n_hit_idx  = r_pidx;
                            n_hit_miss = miss;
                        end
                        if (!slot_valid && !r_free) begin
                            n_free     = 1'b1;
                            n_free_idx = r_pidx;
                        end
                    end
                    if (miss) begin
                        n_mask[r_pidx] = 1'b1;
                        n_cnt          = r_cnt + CNT_W'(1);
                    end
                end
            end

            S_COMMIT: begin
                unique case (r_action)
                    ACT_REGISTER: begin
                        if (r_hit) begin
                            status = ST_CONFLICT;
                        end else if (r_free) begin
                            status               = ST_REGISTERED;
                            o_name_we            = 1'b1;
                            o_sil_we             = 1'b1;
                            o_sil_waddr          = r_free_idx;
                            o_sil_wdata          = '0;
                            n_valid[r_free_idx]  = 1'b1;
                        end else begin
                            status = ST_FULL;
                        end
                    end
                    ACT_RELEASE: begin
                        if (r_hit) begin
                            status              = ST_RELEASED;
                            n_valid[r_hit_idx]  = 1'b0;
                            mask_fin[r_hit_idx] = 1'b0;
                            if (r_hit_miss) begin
                                cnt_fin = r_cnt - CNT_W'(1);
                            end
                        end else begin
                            status = ST_NOT_FOUND;
                        end
                    end
                    ACT_RESPONSE: begin
                        if (r_hit) begin
                            status              = ST_NOTED;
                            o_sil_we            = 1'b1;
                            o_sil_waddr         = r_hit_idx;
                            o_sil_wdata         = '0;
                            mask_fin[r_hit_idx] = 1'b0;
                            if (r_hit_miss) begin
                                cnt_fin = r_cnt - CNT_W'(1);
                            end
                        end else begin
                            status = ST_UNKNOWN;
                        end
                    end
                    ACT_TICK: begin
                        status = ST_TICK;
                    end
                endcase

                n_done                  = 1'b1;
                n_result.status         = status;
                n_result.echo_name      = (r_action == ACT_TICK) ? '0 : r_key;
                n_result.alarm          = (cnt_fin != '0);
                n_result.missing_mask   = 8'(mask_fin);
                n_result.missing_count  = (cnt_fin > CNT_W'(15)) ? 4'd15 : cnt_fin[3:0];
                n_state                 = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_action   <= n_action;
        r_key      <= n_key;
        r_elapsed  <= n_elapsed;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_miss <= n_hit_miss;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_mask     <= n_mask;
        r_cnt      <= n_cnt;
        r_result   <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* design/named_heartbeat_supervisor_top.sv */
// Top level of the named heartbeat supervisor: config registers, slot memories, walker.
// An accepted item walks the n = min(list_size, 8) active slots, then commits its
//   action and posts its result with o_done. The walk reads one slot per cycle
//   through the read address shared by both slot memories, followed by a commit
//   step and a result step.
// A new start is taken in the cycle that carries o_done; the receiver cannot stall.
// Reset (synchronous, active low): all slots invalid, wait_limit 30, list_size 8.
module named_heartbeat_supervisor_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_action,
    input  logic [nhs_pkg::NAME_W-1:0]    i_device_name,
    input  logic [nhs_pkg::ELAPSED_W-1:0] i_elapsed_seconds,
    // result strobe
    output logic                          o_done,
    output logic [2:0]                    o_status,
    output logic [nhs_pkg::NAME_W-1:0]    o_echo_name,
    output logic                          o_alarm,
    output logic [7:0]                    o_missing_mask,
    output logic [3:0]                    o_missing_count,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [nhs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nhs_pkg::CFG_W-1:0]     i_cfg_data
);
    import nhs_pkg::*;

    logic [LIMIT_W-1:0] r_wait_limit;
    logic [LSIZE_W-1:0] r_list_size;

    logic [IDX_W-1:0]   raddr;
    logic [NAME_W-1:0]  name_rdata;
    logic [SIL_W-1:0]   sil_rdata;
    logic               name_we;
    logic [IDX_W-1:0]   name_waddr;
    logic [NAME_W-1:0]  name_wdata;
    logic               sil_we;
    logic [IDX_W-1:0]   sil_waddr;
    logic [SIL_W-1:0]   sil_wdata;
    t_result            result;

    // Hold the configuration; the host must write it only while the block is idle; not enforced here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_limit <= WAIT_LIMIT_RST;
            r_list_size  <= LIST_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WAIT_LIMIT: r_wait_limit <= i_cfg_data;
                CFG_LIST_SIZE:  r_list_size  <= i_cfg_data[LSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Slot names: written when a slot is registered, never cleared.
    nhs_ram #(
        .WIDTH (NAME_W),
        .DEPTH (SLOTS)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (name_waddr),
        .i_wdata (name_wdata),
        .i_raddr (raddr),
        .o_rdata (name_rdata)
    );

    // Silence counters: zeroed on register and response, advanced on tick.
    nhs_ram #(
        .WIDTH (SIL_W),
        .DEPTH (SLOTS)
    ) u_sil_ram (
        .i_clk   (i_clk),
        .i_we    (sil_we),
        .i_waddr (sil_waddr),
        .i_wdata (sil_wdata),
        .i_raddr (raddr),
        .o_rdata (sil_rdata)
    );

    // Walk the active slots, then commit the action and post the result.
    nhs_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_action          (i_action),
        .i_device_name     (i_device_name),
        .i_elapsed_seconds (i_elapsed_seconds),
        .i_wait_limit      (r_wait_limit),
        .i_list_size       (r_list_size),
        .o_busy            (busy),
        .o_done            (o_done),
        .o_result          (result),
        .o_raddr           (raddr),
        .i_name_rdata      (name_rdata),
        .i_sil_rdata       (sil_rdata),
        .o_name_we         (name_we),
        .o_name_waddr      (name_waddr),
        .o_name_wdata      (name_wdata),
        .o_sil_we          (sil_we),
        .o_sil_waddr       (sil_waddr),
        .o_sil_wdata       (sil_wdata)
    );

    assign o_status        = result.status;
    assign o_echo_name     = result.echo_name;
    assign o_alarm         = result.alarm;
    assign o_missing_mask  = result.missing_mask;
    assign o_missing_count = result.missing_count;

endmodule

/* design/nhs_checker.sv */
// Port-level checks of the named heartbeat supervisor and their bind.
module nhs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_alarm,
    input logic [3:0] o_missing_count
);

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // the result goes out exactly as the block turns idle
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // results are single-cycle strobes, never back to back
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    // alarm follows the missing count
    a_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_alarm == (o_missing_count != 4'd0)))
        else $error("alarm disagrees with missing count");

endmodule

bind named_heartbeat_supervisor_top nhs_checker u_nhs_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the named heartbeat supervisor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nhs_pkg::*;

    // One planned item, with an optional hand-written expected report.
    typedef struct {
        t_action              act;
        logic [NAME_W-1:0]    name;
        logic [ELAPSED_W-1:0] secs;
        bit                   typed;
        t_result              want;
    } t_row;

    localparam int POOL_N    = 12;
    localparam int PHASES    = 9;
    localparam int PHASE_LEN = 211;

    // DUT side
    logic                 i_clk    = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 start    = 1'b0;
    logic [1:0]           act_in   = '0;
    logic [NAME_W-1:0]    name_in  = '0;
    logic [ELAPSED_W-1:0] secs_in  = '0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 busy;
    logic                 done;
    logic [2:0]           status;
    logic [NAME_W-1:0]    echo;
    logic                 alarm;
    logic [7:0]           miss_mask;
    logic [3:0]           miss_count;

    // Shadow copy of the supervisor table and its registers
    logic [NAME_W-1:0]  tab_name    [SLOTS];
    bit                 tab_valid   [SLOTS];
    logic [SIL_W-1:0]   tab_silence [SLOTS];
    logic [LIMIT_W-1:0] cur_limit;
    logic [LSIZE_W-1:0] cur_size;

    t_result reports_due [$];
    t_row    plan [$];
    t_result head;
    int      fails = 0;

    named_heartbeat_supervisor_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (act_in),
        .i_device_name     (name_in),
        .i_elapsed_seconds (secs_in),
        .o_done            (done),
        .o_status          (status),
        .o_echo_name       (echo),
        .o_alarm           (alarm),
        .o_missing_mask    (miss_mask),
        .o_missing_count   (miss_count),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the shadow table by one item and return the report it causes.
    function automatic t_result predict_report(t_action act, logic [NAME_W-1:0] raw,
                                               logic [ELAPSED_W-1:0] secs);
        t_result           r;
        logic [NAME_W-1:0] key;
        logic [SIL_W:0]    sum;
        int                n;
        int                hit;
        int                cnt;
        bit                placed;
        key = raw & NAME_MASK;
        n   = (int'(cur_size) < SLOTS) ? int'(cur_size) : SLOTS;
        r.echo_name    = key;
        r.missing_mask = '0;
        cnt    = 0;
        placed = 1'b0;
        // first valid active slot holding this name, or -1
        hit = -1;
        for (int i = n - 1; i >= 0; i--)
            if (tab_valid[i] && tab_name[i] == key)
                hit = i;
        case (act)
            ACT_REGISTER: begin
                if (hit >= 0) begin
                    r.status = ST_CONFLICT;
                end else begin
                    r.status = ST_FULL;
                    // take the lowest free active slot, counter cleared
                    for (int i = 0; i < n; i++) begin
                        if (!placed && !tab_valid[i]) begin
                            placed         = 1'b1;
                            tab_valid[i]   = 1'b1;
                            tab_name[i]    = key;
                            tab_silence[i] = '0;
                            r.status       = ST_REGISTERED;
                        end
                    end
                end
            end
            ACT_RELEASE: begin
                if (hit >= 0) begin
                    tab_valid[hit] = 1'b0;
                    r.status       = ST_RELEASED;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            ACT_RESPONSE: begin
                if (hit >= 0) begin
                    tab_silence[hit] = '0;
                    r.status         = ST_NOTED;
                end else begin
                    r.status = ST_UNKNOWN;
                end
            end
            ACT_TICK: begin
                // add elapsed time to every valid active counter, saturating
                for (int i = 0; i < n; i++) begin
                    if (tab_valid[i]) begin
                        sum = {1'b0, tab_silence[i]} + {{(SIL_W + 1 - ELAPSED_W){1'b0}}, secs};
                        tab_silence[i] = sum[SIL_W] ? {SIL_W{1'b1}} : sum[SIL_W-1:0];
                    end
                end
                r.status    = ST_TICK;
                r.echo_name = '0;
            end
        endcase
        // missing means strictly above the wait limit
        for (int i = 0; i < n; i++) begin
            if (tab_valid[i] && tab_silence[i] > {{(SIL_W - LIMIT_W){1'b0}}, cur_limit}) begin
                if (i < 8)
                    r.missing_mask[i] = 1'b1;
                if (cnt < 15)
                    cnt++;
            end
        end
        r.alarm         = (cnt != 0);
        r.missing_count = 4'(cnt);
        return r;
    endfunction

    function automatic void plan_row(t_action act, logic [NAME_W-1:0] name,
                                     logic [ELAPSED_W-1:0] secs);
        t_row r;
        r.act   = act;
        r.name  = name;
        r.secs  = secs;
        r.typed = 1'b0;
        r.want  = '0;
        plan.push_back(r);
    endfunction

    // Row whose report is obvious by hand: record it instead of the predicted one.
    function automatic void plan_known(t_action act, logic [NAME_W-1:0] name,
                                       logic [ELAPSED_W-1:0] secs, t_status st,
                                       logic [NAME_W-1:0] echo_want, logic [7:0] mask,
                                       logic [3:0] cnt);
        t_row r;
        r.act                = act;
        r.name               = name;
        r.secs               = secs;
        r.typed              = 1'b1;
        r.want.status        = st;
        r.want.echo_name     = echo_want;
        r.want.alarm         = (cnt != 0);
        r.want.missing_mask  = mask;
        r.want.missing_count = cnt;
        plan.push_back(r);
    endfunction

    // Present one item, hold it until the block takes it, then record its report.
    task automatic apply_item(input t_row r);
        t_result guess;
        start   <= 1'b1;
        act_in  <= r.act;
        name_in <= r.name;
        secs_in <= r.secs;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        guess = predict_report(r.act, r.name, r.secs);
        reports_due.push_back(r.typed ? r.want : guess);
    endtask

    // Drop start for a random number of cycles, pct percent chance per cycle.
    task automatic idle_gap(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < pct)
                @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every report has come back.
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (reports_due.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_WAIT_LIMIT)
            cur_limit = val[LIMIT_W-1:0];
        else
            cur_size = val[LSIZE_W-1:0];
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fails++;
            $error("%s: expected %0h, got %0h", what, want, got);
        end
    endtask

    // Compare every strobed report with the oldest one still expected.
    always @(posedge i_clk) begin
        if (rst_n && done === 1'b1) begin
            if (reports_due.size() == 0) begin
                fails++;
                $error("report with no item waiting: status %0h", status);
            end else begin
                head = reports_due.pop_front();
                check_field("status", 64'(head.status), 64'(status));
                check_field("echo_name", 64'(head.echo_name), 64'(echo));
                check_field("alarm", 64'(head.alarm), 64'(alarm));
                check_field("missing_mask", 64'(head.missing_mask), 64'(miss_mask));
                check_field("missing_count", 64'(head.missing_count), 64'(miss_count));
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(10_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        logic [NAME_W-1:0]    dn [10];
        logic [NAME_W-1:0]    pool [POOL_N];
        logic [LIMIT_W-1:0]   lim_tab [PHASES];
        logic [LSIZE_W-1:0]   size_tab [PHASES];
        logic [63:0]          wide;
        logic [ELAPSED_W-1:0] all_secs;
        t_row                 r;
        int                   sel;
        int                   span;
        int                   pct;

        // Directed names: zero, all ones, single bits, alternating and other patterns.
        dn[0] = '0;
        dn[1] = {NAME_W{1'b1}};
        dn[2] = 56'h00_0000_0000_0041;
        dn[3] = 56'h80_0000_0000_0000;
        dn[4] = 56'h01_2345_6789_ABCD;
        dn[5] = 56'hFE_DCBA_9876_5432;
        dn[6] = 56'h55_5555_5555_5555;
        dn[7] = 56'hAA_AAAA_AAAA_AAAA;
        dn[8] = 56'h00_0000_0000_0001;
        dn[9] = 56'h7F_FFFF_FFFF_FFFE;
        all_secs = {ELAPSED_W{1'b1}};

        // Random names are drawn mostly from a small pool so that register,
        // release and response find each other; the pool exceeds the table.
        pool[0] = '0;
        pool[1] = {NAME_W{1'b1}};
        for (int i = 2; i < POOL_N; i++) begin
            wide    = {$urandom(), $urandom()};
            pool[i] = wide[NAME_W-1:0];
        end

        // Register settings per phase: extremes of both, list_size of zero
        // and above the slot count included.
        lim_tab  = '{16'd30, 16'd0, 16'hFFFF, 16'd100, 16'd7, 16'd0, 16'd12, 16'hFFFF, 16'd30};
        size_tab = '{4'd8, 4'd1, 4'd8, 4'd5, 4'd3, 4'd0, 4'd15, 4'd2, 4'd8};

        // Shadow state after reset
        for (int i = 0; i < SLOTS; i++) begin
            tab_name[i]    = '0;
            tab_valid[i]   = 1'b0;
            tab_silence[i] = '0;
        end
        cur_limit = WAIT_LIMIT_RST;
        cur_size  = LIST_SIZE_RST;

        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings (limit 30, eight slots).
        // Empty table: every lookup misses, a tick reports nothing.
        plan_known(ACT_RESPONSE, dn[2], all_secs, ST_UNKNOWN, dn[2], 8'h00, 4'd0);
        plan_known(ACT_RELEASE, dn[2], 16'h0000, ST_NOT_FOUND, dn[2], 8'h00, 4'd0);
        plan_known(ACT_TICK, dn[2], all_secs, ST_TICK, '0, 8'h00, 4'd0);
        // The zero name is an ordinary name; a duplicate is refused.
        plan_known(ACT_REGISTER, dn[0], 16'h0000, ST_REGISTERED, dn[0], 8'h00, 4'd0);
        plan_known(ACT_REGISTER, dn[0], 16'h1234, ST_CONFLICT, dn[0], 8'h00, 4'd0);
        plan_known(ACT_REGISTER, dn[1], 16'h0000, ST_REGISTERED, dn[1], 8'h00, 4'd0);
        // Fill the rest of the table, then one more is refused as full.
        for (int i = 2; i < 8; i++)
            plan_known(ACT_REGISTER, dn[i], 16'h0000, ST_REGISTERED, dn[i], 8'h00, 4'd0);
        plan_known(ACT_REGISTER, dn[8], 16'h0000, ST_FULL, dn[8], 8'h00, 4'd0);
        // One second past the limit: every device goes missing.
        plan_known(ACT_TICK, dn[0], 16'd31, ST_TICK, '0, 8'hFF, 4'd8);
        plan_known(ACT_RESPONSE, dn[1], 16'h0000, ST_NOTED, dn[1], 8'hFD, 4'd7);
        plan_known(ACT_RELEASE, dn[0], 16'h0000, ST_RELEASED, dn[0], 8'hFC, 4'd6);
        // A freed slot is reused with its counter cleared.
        plan_known(ACT_REGISTER, dn[9], 16'h0000, ST_REGISTERED, dn[9], 8'hFC, 4'd6);
        // Exactly at the limit is not missing.
        plan_known(ACT_TICK, dn[9], 16'd30, ST_TICK, '0, 8'hFC, 4'd6);
        plan_row(ACT_TICK, dn[5], 16'd1);
        plan_row(ACT_RESPONSE, dn[8], 16'h00FF);
        plan_row(ACT_RELEASE, dn[3], 16'h0000);
        plan_row(ACT_REGISTER, dn[1], 16'h0000);
        plan_row(ACT_REGISTER, dn[3], 16'h0000);
        plan_row(ACT_TICK, dn[1], 16'd0);
        plan_row(ACT_RESPONSE, dn[9], 16'h0000);

        foreach (plan[i]) begin
            apply_item(plan[i]);
            idle_gap(9);
        end

        // Random phases: the sender idles 9 percent, then 50, then never.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            cfg_write(CFG_WAIT_LIMIT, CFG_W'(lim_tab[ph]));
            cfg_write(CFG_LIST_SIZE, CFG_W'(size_tab[ph]));
            pct  = (ph < 3) ? 9 : ((ph < 6) ? 50 : 0);
            span = (int'(lim_tab[ph]) < 32000) ? 2 * int'(lim_tab[ph]) + 2 : 65535;
            for (int k = 0; k < PHASE_LEN; k++) begin
                wide    = {$urandom(), $urandom()};
                r.typed = 1'b0;
                r.want  = '0;
                r.secs  = ELAPSED_W'($urandom_range(65535));
                sel     = $urandom_range(99);
                if (sel < 10) begin
                    // noise: any action with a name nobody registered
                    r.act  = t_action'($urandom_range(3));
                    r.name = wide[NAME_W-1:0];
                end else begin
                    r.name = pool[$urandom_range(POOL_N - 1)];
                    sel    = $urandom_range(99);
                    if (sel < 30)
                        r.act = ACT_REGISTER;
                    else if (sel < 45)
                        r.act = ACT_RELEASE;
                    else if (sel < 70)
                        r.act = ACT_RESPONSE;
                    else
                        r.act = ACT_TICK;
                    if (r.act == ACT_TICK) begin
                        // mostly short ticks so devices drift across the limit
                        sel = $urandom_range(99);
                        if (sel < 60)
                            r.secs = ELAPSED_W'($urandom_range(12));
                        else if (sel < 85)
                            r.secs = ELAPSED_W'($urandom_range(span));
                    end
                end
                apply_item(r);
                idle_gap(pct);
            end
        end

        // Let the last reports come home, then check that none is still due.
        drain();
        repeat (12) @(posedge i_clk);
        if (reports_due.size() != 0) begin
            fails++;
            $error("%0d items never got a report", reports_due.size());
        end
        if (fails == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
